### hw/rtl/rlf_pkg.sv
`default_nettype none

package rlf_pkg;

   localparam int COLOR_W   = 8;
   localparam int FADE_W    = 16;
   localparam int NUM_LANES = 3;

   typedef logic [COLOR_W-1:0] level_type;
   typedef logic [FADE_W-1:0]  fade_type;

   typedef enum logic [0:0] {
      CMD_TICK  = 1'b0,
      CMD_COLOR = 1'b1
   } cmd_type;

   typedef struct packed {
      logic      cmd;
      level_type red_in;
      level_type green_in;
      level_type blue_in;
   } req_word_type;

   typedef struct packed {
      level_type red_out;
      level_type green_out;
      level_type blue_out;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic step;
   } lane_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/rlf_stream_if.sv
`default_nettype none

interface rlf_stream_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/rlf_lane.sv
`default_nettype none

module rlf_lane #(
   parameter int CHANNEL_BITS = 8,
   parameter int TIME_BITS    = 16
) (
   input  logic                     clock,
   input  rlf_pkg::lane_ctl_type    ctl,
   input  logic [CHANNEL_BITS-1:0]  src_level,
   input  logic [CHANNEL_BITS-1:0]  dst_level,
   input  logic [TIME_BITS-1:0]     count,
   input  logic [TIME_BITS-1:0]     span,
   output logic [CHANNEL_BITS-1:0]  level
);
   import rlf_pkg::*;

   localparam int PROD_W = CHANNEL_BITS + TIME_BITS;
   localparam int NUM_W  = PROD_W + 1;

   logic [CHANNEL_BITS-1:0] from_ff;
   logic                    down_ff;
   logic [CHANNEL_BITS-1:0] mag_ff;
   logic [TIME_BITS-1:0]    count_ff;
   logic [TIME_BITS-1:0]    span_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [NUM_W-1:0]        dsr_ff;
   logic [CHANNEL_BITS-1:0] quo_ff;

   logic [PROD_W-1:0]       prod;
   logic [TIME_BITS-1:0]    bias;
   logic [NUM_W-1:0]        num_in;
   logic                    ge;

   // falling channel rounds the step up so the level floors toward minus infinity
   assign prod   = PROD_W'(mag_ff) * PROD_W'(count_ff);
   assign bias   = down_ff ? (span_ff - TIME_BITS'(1)) : '0;
   assign num_in = NUM_W'(prod) + NUM_W'(bias);
   assign ge     = (num_ff >= dsr_ff);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         from_ff  <= src_level;
         down_ff  <= (dst_level < src_level);
         mag_ff   <= (dst_level < src_level) ? (src_level - dst_level)
                                             : (dst_level - src_level);
         count_ff <= count;
         span_ff  <= span;
         dsr_ff   <= NUM_W'(span) << (CHANNEL_BITS - 1);
      end else if (ctl.mul) begin
         num_ff <= num_in;
         quo_ff <= '0;
      end else if (ctl.step) begin
         if (ge) begin
            num_ff <= num_ff - dsr_ff;
         end
         quo_ff <= {quo_ff[CHANNEL_BITS-2:0], ge};
         dsr_ff <= dsr_ff >> 1;
      end
   end

   assign level = down_ff ? (from_ff - quo_ff) : (from_ff + quo_ff);

endmodule

`default_nettype wire

### hw/rtl/rgb_linear_fader.sv
`default_nettype none
// Tick word: on accept the lanes load, then ST_MUL forms the product, ST_DIV runs
//   the one-bit-per-cycle restoring divider in each colour lane, and ST_DONE
//   registers the result when the output is free; next word taken in ST_IDLE.
// New-colour word: no result, next word the cycle after.
// The output register lets a word be accepted while a result waits.
// Synchronous active-high reset clears colours, tick count, fade time and rsp valid.

module rgb_linear_fader #(
   parameter int CHANNEL_BITS = 8,
   parameter int TIME_BITS    = 16
) (
   input  logic         clock,
   input  logic         reset,
   rlf_stream_if.sink   req_chan,
   rlf_stream_if.source rsp_chan,
   rlf_stream_if.sink   csr_chan
);
   import rlf_pkg::*;

   localparam int CNT_W  = TIME_BITS + 1;
   localparam int STEP_W = $clog2(CHANNEL_BITS);

   state_type               state_ff, state_in;
   fade_type                fade_ff;
   logic [CHANNEL_BITS-1:0] start_ff  [NUM_LANES];
   logic [CHANNEL_BITS-1:0] target_ff [NUM_LANES];
   logic [CHANNEL_BITS-1:0] req_color [NUM_LANES];
   logic [CHANNEL_BITS-1:0] lane_level[NUM_LANES];
   logic [CHANNEL_BITS-1:0] sel_level [NUM_LANES];
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [STEP_W-1:0]       step_ff;
   logic                    use_target_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_word_ff;

   logic [TIME_BITS-1:0]    span;
   logic                    req_fire;
   logic                    tick_fire;
   logic                    color_fire;
   logic                    out_free;
   logic                    out_load;
   lane_ctl_type            lane_ctl;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign tick_fire  = req_fire && (req_chan.data.cmd == CMD_TICK);
   assign color_fire = req_fire && (req_chan.data.cmd == CMD_COLOR);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign out_load   = (state_ff == ST_DONE) && out_free;

   assign span     = TIME_BITS'(fade_ff);
   assign count_in = (&count_ff) ? count_ff : (count_ff + CNT_W'(1));

   assign req_color[0] = CHANNEL_BITS'(req_chan.data.red_in);
   assign req_color[1] = CHANNEL_BITS'(req_chan.data.green_in);
   assign req_color[2] = CHANNEL_BITS'(req_chan.data.blue_in);

   assign lane_ctl.load = tick_fire;
   assign lane_ctl.mul  = (state_ff == ST_MUL);
   assign lane_ctl.step = (state_ff == ST_DIV);

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      rlf_lane #(
         .CHANNEL_BITS (CHANNEL_BITS),
         .TIME_BITS    (TIME_BITS)
      ) u_lane (
         .clock     (clock),
         .ctl       (lane_ctl),
         .src_level (start_ff[i]),
         .dst_level (target_ff[i]),
         .count     (count_in[TIME_BITS-1:0]),
         .span      (span),
         .level     (lane_level[i])
      );
      assign sel_level[i] = use_target_ff ? target_ff[i] : lane_level[i];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (tick_fire) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fade_ff       <= '0;
         count_ff      <= '0;
         step_ff       <= '0;
         use_target_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_LANES; i++) begin
            start_ff[i]  <= '0;
            target_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            fade_ff <= csr_chan.data;
         end
         if (color_fire) begin
            count_ff <= '0;
            for (int i = 0; i < NUM_LANES; i++) begin
               start_ff[i]  <= target_ff[i];
               target_ff[i] <= req_color[i];
            end
         end else if (tick_fire) begin
            count_ff      <= count_in;
            use_target_ff <= (span == '0) || (count_in > CNT_W'(span));
         end
         if (state_ff == ST_MUL) begin
            step_ff <= STEP_W'(CHANNEL_BITS - 1);
         end else if (state_ff == ST_DIV) begin
            step_ff <= step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_word_ff.red_out   <= COLOR_W'(sel_level[0]);
         rsp_word_ff.green_out <= COLOR_W'(sel_level[1]);
         rsp_word_ff.blue_out  <= COLOR_W'(sel_level[2]);
      end
   end

endmodule

`default_nettype wire

### hw/rtl/rlf_checker.sv
`default_nettype none

module rlf_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_cmd,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rlf_pkg::rsp_word_type rsp_data
);
   import rlf_pkg::*;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp word changed while stalled");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_cmd == CMD_TICK) |=> !req_ready)
      else $error("tick word did not start the lanes");

   a_color_free: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_cmd == CMD_COLOR) |=> req_ready)
      else $error("new-colour word stalled the input");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("rsp word appeared with no tick in flight");

endmodule

bind rgb_linear_fader rlf_checker u_rlf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_cmd   (req_chan.data.cmd),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

`default_nettype wire
